FILE: hdl/dtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient detector package
// Shared state codes, register indexes, reset values and status types.
// ----------------------------------------------------------------------------
package dtd_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_RELEASE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ATTACK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RELEASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NORM_MARGIN  = 3'd4;

	// Reset values of the poles (Q0.24) and of the margin (unsigned Q15.0, in magnitude units).
	localparam logic [31:0] RST_FAST_ATTACK  = 32'd16401054;
	localparam logic [31:0] RST_FAST_RELEASE = 32'd16739215;
	localparam logic [31:0] RST_SLOW_ATTACK  = 32'd16758204;
	localparam logic [31:0] RST_SLOW_RELEASE = 32'd16773412;
	localparam int MARGIN_W = 15;
	localparam logic [MARGIN_W-1:0] RST_NORM_MARGIN = 15'd33;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_PREP,
		BK_DIV,
		BK_OUT
	} bk_state_t;

	// Handshake status that the back end reports to the top level.
	typedef struct packed {
		logic in_ready;
		logic out_valid;
	} bk_status_t;

endpackage

FILE: hdl/dtd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-entry item queue
// Small register queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module dtd_fifo #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = 1;
	localparam int CNT_W = 2;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: hdl/dtd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient detector front end
// Accepts samples, rectifies them and queues the magnitudes for the back end.
// ----------------------------------------------------------------------------
module dtd_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          q_valid,
	input  logic                          q_pop,
	output logic [SAMPLE_BITS-2:0]        q_rect
);

	localparam int MAG_W = SAMPLE_BITS - 1;

	logic [SAMPLE_BITS-1:0] neg;
	logic                   is_min;
	logic [MAG_W-1:0]       rect;
	logic                   q_empty;

	// Rectify; the most negative sample saturates to full scale.
	assign neg    = SAMPLE_BITS'(0) - SAMPLE_BITS'(sample);
	assign is_min = (sample == {1'b1, {MAG_W{1'b0}}});
	always_comb begin
		if (!sample[SAMPLE_BITS-1]) begin
			rect = sample[MAG_W-1:0];
		end else if (is_min) begin
			rect = '1;
		end else begin
			rect = neg[MAG_W-1:0];
		end
	end

	dtd_fifo #(
		.WIDTH (MAG_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (rect),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_rect),
		.empty   (q_empty)
	);

	assign q_valid = ~q_empty;

endmodule

FILE: hdl/dtd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient detector back end
// Runs both envelope followers with serial multipliers, then normalizes the
// outputs with serial dividers when their sum exceeds the level plus margin.
// ----------------------------------------------------------------------------
module dtd_back #(
	parameter int COEF_FRAC_BITS = 24,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [SAMPLE_BITS-2:0]        in_rect,
	input  logic                          out_ready,
	output logic [2*(SAMPLE_BITS-1)-1:0]  out_data,
	output dtd_pkg::bk_status_t           status,
	input  logic [COEF_FRAC_BITS-1:0]     fast_attack,
	input  logic [COEF_FRAC_BITS-1:0]     fast_release,
	input  logic [COEF_FRAC_BITS-1:0]     slow_attack,
	input  logic [COEF_FRAC_BITS-1:0]     slow_release,
	input  logic [dtd_pkg::MARGIN_W-1:0]  margin
);

	localparam int MAG_W  = SAMPLE_BITS - 1;
	localparam int LVL_W  = MAG_W + COEF_FRAC_BITS;
	localparam int K_W    = COEF_FRAC_BITS + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int CMP_W  = ((MAG_W > dtd_pkg::MARGIN_W) ? MAG_W : dtd_pkg::MARGIN_W) + 1;
	localparam int CNT_MAX = (COEF_FRAC_BITS > MAG_W) ? COEF_FRAC_BITS : MAG_W;
	localparam int CNT_W  = $clog2(CNT_MAX + 1);

	dtd_pkg::bk_state_t state_q;
	dtd_pkg::bk_state_t state_d;

	logic [LVL_W-1:0] fast_lvl_q;
	logic [LVL_W-1:0] slow_lvl_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] rect_q;
	logic             up_f_q;
	logic             up_s_q;
	logic [LVL_W-1:0] diff_f_q;
	logic [LVL_W-1:0] diff_s_q;
	logic [K_W-1:0]   k_f_q;
	logic [K_W-1:0]   k_s_q;
	logic [LVL_W:0]   acc_f_q;
	logic [LVL_W:0]   acc_s_q;
	logic [MAG_W-1:0] trans_q;
	logic [MAG_W-1:0] sus_q;
	logic [MAG_W-1:0] total_q;
	logic [MAG_W-1:0] rem_t_q;
	logic [MAG_W-1:0] rem_s_q;
	logic [MAG_W-1:0] dvd_t_q;
	logic [MAG_W-1:0] dvd_s_q;

	logic             take;
	logic [LVL_W-1:0] tgt;
	logic             up_f;
	logic             up_s;
	logic [LVL_W:0]   sum_f;
	logic [LVL_W:0]   sum_s;
	logic             mul_last;
	logic [MAG_W-1:0] fast_lv;
	logic [MAG_W-1:0] slow_lv;
	logic [MAG_W-1:0] trans;
	logic [CMP_W-1:0] total_c;
	logic [CMP_W-1:0] limit_c;
	logic             norm;
	logic [PROD_W-1:0] prod_t;
	logic [PROD_W-1:0] prod_s;
	logic [MAG_W:0]   sh_t;
	logic [MAG_W:0]   sh_s;
	logic             ge_t;
	logic             ge_s;
	logic [MAG_W:0]   red_t;
	logic [MAG_W:0]   red_s;
	logic             div_last;

	assign take = in_valid & status.in_ready;

	// Attack test and step direction against the new target level.
	assign tgt  = LVL_W'(in_rect) << COEF_FRAC_BITS;
	assign up_f = (tgt > fast_lvl_q);
	assign up_s = (tgt > slow_lvl_q);

	// One partial product a cycle, lowest bit of one minus the pole first.
	assign sum_f    = acc_f_q + (k_f_q[0] ? {1'b0, diff_f_q} : '0);
	assign sum_s    = acc_s_q + (k_s_q[0] ? {1'b0, diff_s_q} : '0);
	assign mul_last = (cnt_q == CNT_W'(COEF_FRAC_BITS));

	// Envelope outputs, transient part and normalization test.
	always_comb begin
		fast_lv = fast_lvl_q[LVL_W-1:COEF_FRAC_BITS];
		slow_lv = slow_lvl_q[LVL_W-1:COEF_FRAC_BITS];
		trans   = (fast_lv > slow_lv) ? (fast_lv - slow_lv) : '0;
		total_c = CMP_W'(trans) + CMP_W'(slow_lv);
		limit_c = CMP_W'(rect_q) + CMP_W'(margin);
		norm    = (total_c > limit_c);
		prod_t  = PROD_W'(trans) * PROD_W'(rect_q);
		prod_s  = PROD_W'(slow_lv) * PROD_W'(rect_q);
	end

	// One quotient bit a cycle; the remainder always stays below the divisor.
	assign sh_t     = {rem_t_q, dvd_t_q[MAG_W-1]};
	assign sh_s     = {rem_s_q, dvd_s_q[MAG_W-1]};
	assign ge_t     = (sh_t >= {1'b0, total_q});
	assign ge_s     = (sh_s >= {1'b0, total_q});
	assign red_t    = ge_t ? (sh_t - {1'b0, total_q}) : sh_t;
	assign red_s    = ge_s ? (sh_s - {1'b0, total_q}) : sh_s;
	assign div_last = (cnt_q == CNT_W'(MAG_W - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dtd_pkg::BK_IDLE: begin
				if (in_valid) begin
					state_d = dtd_pkg::BK_MUL;
				end
			end
			dtd_pkg::BK_MUL: begin
				if (mul_last) begin
					state_d = dtd_pkg::BK_PREP;
				end
			end
			dtd_pkg::BK_PREP: begin
				state_d = norm ? dtd_pkg::BK_DIV : dtd_pkg::BK_OUT;
			end
			dtd_pkg::BK_DIV: begin
				if (div_last) begin
					state_d = dtd_pkg::BK_OUT;
				end
			end
			dtd_pkg::BK_OUT: begin
				if (out_ready) begin
					state_d = dtd_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = dtd_pkg::BK_IDLE;
			end
		endcase
	end

	// Handshake outputs.
	always_comb begin
		status.in_ready  = (state_q == dtd_pkg::BK_IDLE);
		status.out_valid = (state_q == dtd_pkg::BK_OUT);
		out_data         = {trans_q, sus_q};
	end

	// State, step counter and envelope levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dtd_pkg::BK_IDLE;
			cnt_q      <= '0;
			fast_lvl_q <= '0;
			slow_lvl_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				dtd_pkg::BK_MUL: begin
					if (mul_last) begin
						cnt_q      <= '0;
						fast_lvl_q <= up_f_q ? (fast_lvl_q + sum_f[LVL_W-1:0])
								: (fast_lvl_q - sum_f[LVL_W-1:0]);
						slow_lvl_q <= up_s_q ? (slow_lvl_q + sum_s[LVL_W-1:0])
								: (slow_lvl_q - sum_s[LVL_W-1:0]);
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				dtd_pkg::BK_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			dtd_pkg::BK_IDLE: begin
				if (take) begin
					rect_q   <= in_rect;
					up_f_q   <= up_f;
					up_s_q   <= up_s;
					diff_f_q <= up_f ? (tgt - fast_lvl_q) : (fast_lvl_q - tgt);
					diff_s_q <= up_s ? (tgt - slow_lvl_q) : (slow_lvl_q - tgt);
					k_f_q    <= (K_W'(1) << COEF_FRAC_BITS)
							- {1'b0, (up_f ? fast_attack : fast_release)};
					k_s_q    <= (K_W'(1) << COEF_FRAC_BITS)
							- {1'b0, (up_s ? slow_attack : slow_release)};
					acc_f_q  <= '0;
					acc_s_q  <= '0;
				end
			end
			dtd_pkg::BK_MUL: begin
				acc_f_q <= sum_f >> 1;
				acc_s_q <= sum_s >> 1;
				k_f_q   <= k_f_q >> 1;
				k_s_q   <= k_s_q >> 1;
			end
			dtd_pkg::BK_PREP: begin
				trans_q <= trans;
				sus_q   <= slow_lv;
				total_q <= total_c[MAG_W-1:0];
				rem_t_q <= prod_t[PROD_W-1:MAG_W];
				dvd_t_q <= prod_t[MAG_W-1:0];
				rem_s_q <= prod_s[PROD_W-1:MAG_W];
				dvd_s_q <= prod_s[MAG_W-1:0];
			end
			dtd_pkg::BK_DIV: begin
				rem_t_q <= red_t[MAG_W-1:0];
				rem_s_q <= red_s[MAG_W-1:0];
				dvd_t_q <= {dvd_t_q[MAG_W-2:0], ge_t};
				dvd_s_q <= {dvd_s_q[MAG_W-2:0], ge_s};
				if (div_last) begin
					trans_q <= {dvd_t_q[MAG_W-2:0], ge_t};
					sus_q   <= {dvd_s_q[MAG_W-2:0], ge_s};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/differential_transient_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential transient detector
// Fast and slow envelope followers on the rectified sample; reports the
// positive fast-minus-slow difference and the slow level, normalized.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Fields
//  input     push / full             sample
//  result    empty / pop             transient_amount, sustain_amount
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The back end works on one item at a time and takes a new one only after
// handing on the last result; the serial envelope multipliers, and the
// serial dividers when an item is normalized, make up its processing time.
// Two items wait in the input queue and two results in the output queue,
// so either side may stall without stopping the other at once.
// Reset clears the envelopes and loads the default poles and margin.
// ----------------------------------------------------------------------------
module differential_transient_detector #(
	parameter int COEF_FRAC_BITS = 24,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic signed [SAMPLE_BITS-1:0]  sample,
	output logic                           empty,
	input  logic                           pop,
	output logic [SAMPLE_BITS-2:0]         transient_amount,
	output logic [SAMPLE_BITS-2:0]         sustain_amount,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dtd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [((COEF_FRAC_BITS > dtd_pkg::MARGIN_W) ? COEF_FRAC_BITS
			: dtd_pkg::MARGIN_W)-1:0] cfg_data
);

	localparam int MAG_W = SAMPLE_BITS - 1;
	localparam int RES_W = 2 * MAG_W;

	logic [COEF_FRAC_BITS-1:0]    fast_attack_q;
	logic [COEF_FRAC_BITS-1:0]    fast_release_q;
	logic [COEF_FRAC_BITS-1:0]    slow_attack_q;
	logic [COEF_FRAC_BITS-1:0]    slow_release_q;
	logic [dtd_pkg::MARGIN_W-1:0] margin_q;

	logic                 front_valid;
	logic                 front_pop;
	logic [MAG_W-1:0]     front_rect;
	dtd_pkg::bk_status_t  bk_status;
	logic [RES_W-1:0]     bk_data;
	logic                 res_full;
	logic                 res_wr;
	logic [RES_W-1:0]     res_data;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_attack_q  <= dtd_pkg::RST_FAST_ATTACK[COEF_FRAC_BITS-1:0];
			fast_release_q <= dtd_pkg::RST_FAST_RELEASE[COEF_FRAC_BITS-1:0];
			slow_attack_q  <= dtd_pkg::RST_SLOW_ATTACK[COEF_FRAC_BITS-1:0];
			slow_release_q <= dtd_pkg::RST_SLOW_RELEASE[COEF_FRAC_BITS-1:0];
			margin_q       <= dtd_pkg::RST_NORM_MARGIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dtd_pkg::CFG_FAST_ATTACK: begin
					fast_attack_q <= cfg_data[COEF_FRAC_BITS-1:0];
				end
				dtd_pkg::CFG_FAST_RELEASE: begin
					fast_release_q <= cfg_data[COEF_FRAC_BITS-1:0];
				end
				dtd_pkg::CFG_SLOW_ATTACK: begin
					slow_attack_q <= cfg_data[COEF_FRAC_BITS-1:0];
				end
				dtd_pkg::CFG_SLOW_RELEASE: begin
					slow_release_q <= cfg_data[COEF_FRAC_BITS-1:0];
				end
				dtd_pkg::CFG_NORM_MARGIN: begin
					margin_q <= cfg_data[dtd_pkg::MARGIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front end: rectifier and input queue.
	dtd_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.sample  (sample),
		.q_valid (front_valid),
		.q_pop   (front_pop),
		.q_rect  (front_rect)
	);

	assign front_pop = front_valid & bk_status.in_ready;

	// Back end: envelopes and normalization.
	dtd_back #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (front_valid),
		.in_rect      (front_rect),
		.out_ready    (~res_full),
		.out_data     (bk_data),
		.status       (bk_status),
		.fast_attack  (fast_attack_q),
		.fast_release (fast_release_q),
		.slow_attack  (slow_attack_q),
		.slow_release (slow_release_q),
		.margin       (margin_q)
	);

	// Result queue.
	assign res_wr = bk_status.out_valid & ~res_full;

	dtd_fifo #(
		.WIDTH (RES_W)
	) u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (bk_data),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_data),
		.empty   (empty)
	);

	assign transient_amount = res_data[RES_W-1:MAG_W];
	assign sustain_amount   = res_data[MAG_W-1:0];

	// An item taken by the back end starts its work in the next cycle.
	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(front_valid && bk_status.in_ready) |=> !bk_status.in_ready)
		else $error("back end still idle after taking an item");

	// A finished result holds while the result queue is full.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_status.out_valid && res_full) |=> bk_status.out_valid)
		else $error("result dropped while result queue full");

	// The back end never offers a result while it is ready for a new item.
	a_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.out_valid |-> !bk_status.in_ready)
		else $error("back end ready and holding a result at once");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient detector testbench
// Drives signed samples into the detector through its input
// queue and checks every result against a cycle-free model of the fast and
// slow envelope followers and of the normalization step. The run steps
// through several pole and margin settings, the extremes among them, with
// random idling on both queue sides.
// ----------------------------------------------------------------------------
module testbench;

	localparam int COEF_BITS  = 24;
	localparam int IDX_W      = dtd_pkg::CFG_IDX_W;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		logic [14:0] trans_amt;
		logic [14:0] sus_amt;
	} amounts_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [15:0] sample = '0;
	logic empty;
	logic pop = 1'b0;
	logic [14:0] transient_amount;
	logic [14:0] sustain_amount;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [COEF_BITS-1:0] cfg_data = '0;

	// Model copy of the registers and of the two envelopes.
	logic [23:0] pole_fast_att = dtd_pkg::RST_FAST_ATTACK[23:0];
	logic [23:0] pole_fast_rel = dtd_pkg::RST_FAST_RELEASE[23:0];
	logic [23:0] pole_slow_att = dtd_pkg::RST_SLOW_ATTACK[23:0];
	logic [23:0] pole_slow_rel = dtd_pkg::RST_SLOW_RELEASE[23:0];
	logic [14:0] margin_val = dtd_pkg::RST_NORM_MARGIN;
	logic [63:0] fast_level = '0;
	logic [63:0] slow_level = '0;

	logic [15:0] pending_samples[$];
	amounts_t expected_amounts[$];

	int n_queued = 0;
	int n_launched = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_cfg_writes = 0;
	int n_normalized = 0;
	int cycle_count = 0;
	bit no_idle = 1'b0;
	bit sender_hold = 1'b0;

	differential_transient_detector dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.sample           (sample),
		.empty            (empty),
		.pop              (pop),
		.transient_amount (transient_amount),
		.sustain_amount   (sustain_amount),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// One envelope update: move toward the shifted magnitude by a pole-scaled step.
	function automatic logic [63:0] follow_level(input logic [63:0] level,
			input logic [14:0] mag, input logic [23:0] att, input logic [23:0] rel);
		logic [63:0] target;
		logic [63:0] diff;
		logic [63:0] pole;
		logic [63:0] step;
		logic up;
		target = {25'd0, mag, 24'd0};
		up = target > level;
		pole = up ? {40'd0, att} : {40'd0, rel};
		diff = up ? target - level : level - target;
		step = (diff * ((64'd1 << COEF_BITS) - pole)) >> COEF_BITS;
		return up ? level + step : level - step;
	endfunction

	// Rectify one sample, advance both envelopes and queue the expected amounts.
	function automatic void predict_amounts(input logic [15:0] raw);
		logic [16:0] neg;
		logic [31:0] mag;
		logic [31:0] fast_env;
		logic [31:0] slow_env;
		logic [31:0] trans;
		logic [31:0] total;
		amounts_t res;
		if (raw[15]) begin
			neg = 17'h10000 - {1'b0, raw};
			mag = (neg > 17'd32767) ? 32'd32767 : {15'd0, neg};
		end else begin
			mag = {17'd0, raw[14:0]};
		end
		fast_level = follow_level(fast_level, mag[14:0], pole_fast_att, pole_fast_rel);
		slow_level = follow_level(slow_level, mag[14:0], pole_slow_att, pole_slow_rel);
		fast_env = 32'(fast_level >> COEF_BITS);
		slow_env = 32'(slow_level >> COEF_BITS);
		trans = (fast_env > slow_env) ? fast_env - slow_env : 32'd0;
		total = trans + slow_env;
		// Scale both amounts down when their sum overshoots the level plus margin.
		if (total > mag + {17'd0, margin_val}) begin
			trans = trans * mag / total;
			slow_env = slow_env * mag / total;
			n_normalized++;
		end
		res.trans_amt = trans[14:0];
		res.sus_amt = slow_env[14:0];
		expected_amounts.push_back(res);
	endfunction

	// Sender: offers queued samples with a random gap between items.
	always @(posedge clk or negedge arst_n) begin : sender
		logic nxt_push;
		int send_gap;
		if (!arst_n) begin
			push <= 1'b0;
			send_gap = 0;
		end else begin
			nxt_push = push;
			if (push && !full) begin
				predict_amounts(sample);
				n_accepted++;
				nxt_push = 1'b0;
			end
			if (!nxt_push) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_samples.size() > 0 && !sender_hold) begin
					sample <= pending_samples.pop_front();
					nxt_push = 1'b1;
					n_launched++;
					send_gap = no_idle ? 0 : $urandom_range(0, 4);
				end
			end
			push <= nxt_push;
		end
	end

	// Receiver: pops results with random stalls and checks each one.
	always @(posedge clk or negedge arst_n) begin : receiver
		logic nxt_pop;
		int recv_gap;
		amounts_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			recv_gap = 0;
		end else begin
			nxt_pop = pop;
			if (pop && !empty) begin
				if (expected_amounts.size() == 0) begin
					$error("Unexpected result: transient_amount %0d, sustain_amount %0d",
						transient_amount, sustain_amount);
					n_errors++;
				end else begin
					want = expected_amounts.pop_front();
					if (transient_amount !== want.trans_amt) begin
						$error("transient_amount mismatch: expected %0d, actual %0d",
							want.trans_amt, transient_amount);
						n_errors++;
					end
					if (sustain_amount !== want.sus_amt) begin
						$error("sustain_amount mismatch: expected %0d, actual %0d",
							want.sus_amt, sustain_amount);
						n_errors++;
					end
					n_checked++;
				end
				nxt_pop = 1'b0;
				recv_gap = no_idle ? 0 : $urandom_range(0, 4);
			end
			if (!nxt_pop) begin
				if (recv_gap > 0)
					recv_gap--;
				else
					nxt_pop = 1'b1;
			end
			pop <= nxt_pop;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Write one register and mirror it in the model.
	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [23:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			dtd_pkg::CFG_FAST_ATTACK:  pole_fast_att = data;
			dtd_pkg::CFG_FAST_RELEASE: pole_fast_rel = data;
			dtd_pkg::CFG_SLOW_ATTACK:  pole_slow_att = data;
			dtd_pkg::CFG_SLOW_RELEASE: pole_slow_rel = data;
			dtd_pkg::CFG_NORM_MARGIN:  margin_val = data[14:0];
			default: ;
		endcase
		n_cfg_writes++;
	endtask

	// Load all four poles and the margin; the margin data carries junk above bit 14.
	task automatic load_settings(input logic [23:0] fa, input logic [23:0] fr,
			input logic [23:0] sa, input logic [23:0] sr, input logic [14:0] m);
		write_register(dtd_pkg::CFG_FAST_ATTACK, fa);
		write_register(dtd_pkg::CFG_FAST_RELEASE, fr);
		write_register(dtd_pkg::CFG_SLOW_ATTACK, sa);
		write_register(dtd_pkg::CFG_SLOW_RELEASE, sr);
		write_register(dtd_pkg::CFG_NORM_MARGIN, {9'($urandom), m});
	endtask

	task automatic queue_sample(input logic [15:0] s);
		pending_samples.push_back(s);
		n_queued++;
	endtask

	// Wait until every queued sample is taken and every result has come back.
	task automatic wait_drained();
		do @(posedge clk); while (n_accepted != n_queued || expected_amounts.size() != 0);
	endtask

	// A pole close to one, as real envelope followers use.
	function automatic logic [23:0] near_one_pole();
		return 24'hFFFFFF - 24'($urandom & ((1 << $urandom_range(4, 20)) - 1));
	endfunction

	// Random audio: mostly quiet or loud bursts under a random peak, some noise and extremes.
	task automatic queue_random_samples(input int count);
		int done;
		int kind;
		int len;
		int amp;
		int v;
		done = 0;
		while (done < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				queue_sample(16'($urandom));
				done++;
			end else if (kind == 2) begin
				case ($urandom_range(0, 3))
					0: queue_sample(16'h8000);
					1: queue_sample(16'h7FFF);
					2: queue_sample(16'h0000);
					default: queue_sample(16'hFFFF);
				endcase
				done++;
			end else begin
				len = $urandom_range(1, 24);
				amp = (kind < 5) ? $urandom_range(0, 64) : $urandom_range(0, 32768);
				for (int k = 0; k < len && done < count; k++) begin
					v = $urandom_range(0, amp);
					queue_sample(16'($urandom_range(0, 1) ? -v : v));
					done++;
				end
			end
		end
	endtask

	initial begin
		int i;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: silence, full scale both ways, most negative value, release.
		queue_sample(16'h0000);
		queue_sample(16'h7FFF);
		queue_sample(16'h7FFF);
		queue_sample(16'h7FFF);
		queue_sample(16'h8000);
		queue_sample(16'h8001);
		queue_sample(16'hFFFF);
		queue_sample(16'h0001);
		queue_sample(16'h0000);
		queue_sample(16'h0000);
		queue_sample(16'h4000);
		queue_sample(16'hC000);
		queue_sample(16'h0064);
		queue_sample(16'h0000);
		wait_drained();

		// Zero poles make both envelopes jump to the level; unknown indexes are ignored.
		load_settings(24'd0, 24'd0, 24'd0, 24'd0, 15'd0);
		for (i = int'(dtd_pkg::CFG_NORM_MARGIN) + 1; i < (1 << IDX_W); i++)
			write_register(IDX_W'(i), 24'($urandom));
		queue_sample(16'h4E20);
		queue_sample(16'h8000);
		queue_sample(16'h0000);
		queue_sample(16'h0007);
		queue_sample(16'hFFF9);
		queue_sample(16'h7FFF);
		wait_drained();

		// Largest poles and margin: envelopes barely move.
		load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF);
		queue_sample(16'h7FFF);
		queue_sample(16'h7FFF);
		queue_sample(16'h7FFF);
		queue_sample(16'h8000);
		queue_sample(16'h0000);
		wait_drained();

		// Random phases, each under its own settings.
		for (int p = 0; p < 8; p++) begin
			no_idle = (p == 3);
			case (p)
				0: load_settings(dtd_pkg::RST_FAST_ATTACK[23:0],
					dtd_pkg::RST_FAST_RELEASE[23:0],
					dtd_pkg::RST_SLOW_ATTACK[23:0],
					dtd_pkg::RST_SLOW_RELEASE[23:0],
					dtd_pkg::RST_NORM_MARGIN);
				1, 7: load_settings(24'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom), 15'($urandom));
				2: load_settings(24'd0, 24'($urandom_range(0, 65535)), 24'hFFFFFF,
					near_one_pole(), 15'd0);
				4: load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF);
				5: load_settings(24'd0, 24'd0, 24'd0, 24'd0, 15'($urandom));
				default: load_settings(near_one_pole(), near_one_pole(), near_one_pole(),
					near_one_pole(), 15'($urandom_range(0, 200)));
			endcase
			queue_random_samples(80);
			// Once, hold the sender halfway until the detector has fully drained.
			if (p == 6) begin
				while (pending_samples.size() > 40) @(posedge clk);
				sender_hold = 1'b1;
				do @(posedge clk); while (n_accepted != n_launched || expected_amounts.size() != 0);
				sender_hold = 1'b0;
			end
			wait_drained();
		end
		no_idle = 1'b0;

		// Let any stray result show up before closing.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_amounts.size() != 0) begin
			$error("%0d expected results never arrived", expected_amounts.size());
			n_errors++;
		end

		$display("Checked %0d results for %0d samples across %0d register writes.",
			n_checked, n_accepted, n_cfg_writes);
		$display("%0d of those results went through normalization.", n_normalized);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
